FILE: hdl/rhsv_pkg.sv
package rhsv_pkg;

    localparam int RGB_W      = 8;
    localparam int HUE_W      = 15;
    localparam int SAT_W      = 13;
    localparam int SAT_FRAC_W = 12;
    localparam int DIFF_W     = RGB_W + 1;

    // Divide stages: one quotient bit per stage, wide enough for either quotient
    localparam int QUO_W      = 15;
    localparam int HUE_NUM_W  = 23;
    localparam int SAT_NUM_W  = RGB_W + SAT_FRAC_W;

    localparam int UNITS_60   = 3840;
    localparam int UNITS_120  = 2 * UNITS_60;
    localparam int UNITS_240  = 4 * UNITS_60;
    localparam int UNITS_360  = 6 * UNITS_60;
    localparam int SAT_ONE    = 1 << SAT_FRAC_W;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic                 vld;
        logic [RGB_W-1:0]     mx;
        logic [RGB_W-1:0]     d;
        logic [HUE_NUM_W-1:0] hue_num;
    } front_t;

endpackage

FILE: hdl/rhsv_front.sv
module rhsv_front
    import rhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [RGB_W-1:0] red,
    input  logic [RGB_W-1:0] green,
    input  logic [RGB_W-1:0] blue,
    output front_t           front
);

    logic [RGB_W-1:0]         mx_next;
    logic [RGB_W-1:0]         mn_next;
    sector_t                  sect_next;
    logic signed [DIFF_W-1:0] dif_next;

    logic                     vld1_reg;
    logic [RGB_W-1:0]         mx1_reg;
    logic [RGB_W-1:0]         d1_reg;
    sector_t                  sect1_reg;
    logic signed [DIFF_W-1:0] dif1_reg;

    logic [HUE_W-1:0]              base;
    logic signed [HUE_NUM_W:0]     base_term;
    logic signed [HUE_NUM_W:0]     diff_term;
    logic signed [HUE_NUM_W:0]     num_sum;

    front_t front_next;
    front_t front_reg;

    // Red wins ties over green and blue, green over blue
    always_comb
    begin
        mx_next = red;
        mn_next = red;
        if (green > mx_next) mx_next = green;
        if (blue > mx_next) mx_next = blue;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next) mn_next = blue;

        if (red >= green && red >= blue)
        begin
            sect_next = SECT_RED;
            dif_next  = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            sect_next = SECT_GREEN;
            dif_next  = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sect_next = SECT_BLUE;
            dif_next  = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else
            vld1_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        mx1_reg   <= mx_next;
        d1_reg    <= mx_next - mn_next;
        sect1_reg <= sect_next;
        dif1_reg  <= dif_next;
    end

    // Numerator base*d + 60deg*diff; a negative red angle wraps by a full turn
    always_comb
    begin
        case (sect1_reg)
            SECT_RED:   base = dif1_reg[DIFF_W-1] ? HUE_W'(UNITS_360) : '0;
            SECT_GREEN: base = HUE_W'(UNITS_120);
            SECT_BLUE:  base = HUE_W'(UNITS_240);
            default:    base = '0;
        endcase
        base_term = $signed({1'b0, HUE_NUM_W'(base) * HUE_NUM_W'(d1_reg)});
        diff_term = (HUE_NUM_W+1)'(dif1_reg) * $signed((HUE_NUM_W+1)'(UNITS_60));
        num_sum   = base_term + diff_term;

        front_next.vld     = vld1_reg;
        front_next.mx      = mx1_reg;
        front_next.d       = d1_reg;
        front_next.hue_num = num_sum[HUE_NUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_reg <= '0;
        else
            front_reg <= front_next;
    end

    assign front = front_reg;

endmodule

FILE: hdl/rhsv_div.sv
module rhsv_div
    import rhsv_pkg::*;
#(
    parameter int NUM_W = 23,
    parameter int DEN_W = 8,
    parameter int QW    = 15
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             out_vld,
    output logic [QW-1:0]    quo
);

    localparam int CMP_W = DEN_W + QW;

    logic             vld_reg [1:QW];
    logic [NUM_W-1:0] rem_reg [1:QW];
    logic [DEN_W-1:0] den_reg [1:QW];
    logic [QW-1:0]    q_reg   [1:QW];

    // One restoring step per stage, most significant quotient bit first.
    // A zero divisor never sets a bit, so the quotient drops to zero.
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int BIT_POS = QW - 1 - s;

        logic             vld_cur;
        logic [NUM_W-1:0] rem_cur;
        logic [DEN_W-1:0] den_cur;
        logic [QW-1:0]    q_cur;
        logic [CMP_W-1:0] rem_ext;
        logic [CMP_W-1:0] sub_ext;
        logic             take;

        if (s == 0)
        begin : g_first
            assign vld_cur = in_vld;
            assign rem_cur = num;
            assign den_cur = den;
            assign q_cur   = '0;
        end
        else
        begin : g_next
            assign vld_cur = vld_reg[s];
            assign rem_cur = rem_reg[s];
            assign den_cur = den_reg[s];
            assign q_cur   = q_reg[s];
        end

        assign rem_ext = CMP_W'(rem_cur);
        assign sub_ext = CMP_W'(den_cur) << BIT_POS;
        assign take    = (den_cur != '0) && (rem_ext >= sub_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= take ? NUM_W'(rem_ext - sub_ext) : rem_cur;
            den_reg[s+1] <= den_cur;
            q_reg[s+1]   <= q_cur | (take ? (QW'(1) << BIT_POS) : '0);
        end
    end

    assign out_vld = vld_reg[QW];
    assign quo     = q_reg[QW];

endmodule

FILE: hdl/rgb_to_hsv_convert_unit.sv
// RGB to HSV converter, one pixel per clock.
//
// Input: pulse start with red, green and blue; the word is taken at any
// rising edge where start is high. busy is held low, so a new pixel may be
// given every cycle.
// Output: done is high for exactly one cycle with hue (1/64 degree units,
// 0..23039), saturation (Q1.12, 0..4096) and brightness (largest channel).
// There is no output backpressure; each result must be taken when shown.
//
// Pipeline from the edge that takes start to the done cycle: one stage finds
// max, min and sector, one forms the hue numerator, and fifteen restoring
// divide stages (one quotient bit each) run the hue and saturation divisions
// side by side. Throughput is one pixel per cycle, with up to 17 pixels in
// flight.
//
// Reset clears every valid bit, so no done pulse follows reset until a new
// pixel is taken; pixels in flight at reset are dropped.
module rgb_to_hsv_convert_unit
    import rhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [RGB_W-1:0] red,
    input  logic [RGB_W-1:0] green,
    input  logic [RGB_W-1:0] blue,
    output logic             done,
    output logic [HUE_W-1:0] hue,
    output logic [SAT_W-1:0] saturation,
    output logic [RGB_W-1:0] brightness
);

    front_t           front;
    logic             hue_vld;
    logic             sat_vld;
    logic [QUO_W-1:0] hue_quo;
    logic [QUO_W-1:0] sat_quo;
    logic [RGB_W-1:0] br_reg [1:QUO_W];

    assign busy = 1'b0;

    rhsv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (start && !busy),
        .red    (red),
        .green  (green),
        .blue   (blue),
        .front  (front)
    );

    rhsv_div #(
        .NUM_W (HUE_NUM_W),
        .DEN_W (RGB_W),
        .QW    (QUO_W)
    ) u_hue_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (front.vld),
        .num     (front.hue_num),
        .den     (front.d),
        .out_vld (hue_vld),
        .quo     (hue_quo)
    );

    rhsv_div #(
        .NUM_W (SAT_NUM_W),
        .DEN_W (RGB_W),
        .QW    (QUO_W)
    ) u_sat_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (front.vld),
        .num     ({front.d, SAT_FRAC_W'(0)}),
        .den     (front.mx),
        .out_vld (sat_vld),
        .quo     (sat_quo)
    );

    // Carry the brightness alongside the divide stages
    always_ff @(posedge clk)
    begin
        br_reg[1] <= front.mx;
        for (int i = 2; i <= QUO_W; i++)
            br_reg[i] <= br_reg[i-1];
    end

    assign done       = hue_vld;
    assign hue        = hue_quo[HUE_W-1:0];
    assign saturation = sat_quo[SAT_W-1:0];
    assign brightness = br_reg[QUO_W];

    a_div_aligned: assert property (@(posedge clk) hue_vld == sat_vld)
        else $error("hue and saturation dividers out of step");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue_quo < QUO_W'(UNITS_360)))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sat_quo <= QUO_W'(SAT_ONE)))
        else $error("saturation above one");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && brightness == '0) |-> (hue == '0 && saturation == '0))
        else $error("black pixel with non-zero hue or saturation");

endmodule
